### src/musical_note_classifier_macros.svh
// assertion macros for the musical note classifier
`ifndef MUSICAL_NOTE_CLASSIFIER_MACROS_SVH
`define MUSICAL_NOTE_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define MCLS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mcls_pkg.sv
// shared constants, tables and types of the musical note classifier
`default_nettype none

package mcls_pkg;

  localparam int OCTAVE_COUNT = 7;
  localparam int NOTE_COUNT   = 12 * OCTAVE_COUNT;
  localparam int NOTE_W       = 7;
  localparam int OCT_W        = $clog2(OCTAVE_COUNT + 1);
  localparam int SEMI_W       = 4;
  localparam int FREQ_W       = 24;
  localparam int THR_W        = 16;
  localparam int RATIO_W      = 17;
  localparam int MUL_W        = 2 * FREQ_W;
  localparam int PROD_W       = FREQ_W + RATIO_W;
  localparam int ROUND_W      = PROD_W + 1;
  localparam int NOTE_FULL_W  = 33;
  localparam int THRF_W       = FREQ_W + THR_W;
  localparam int CMP_W        = NOTE_FULL_W + 16;
  localparam int ERR_W        = 16;
  localparam int Q_W          = 15;
  localparam int DIV_NUM_W    = 40;
  localparam int DIV_DEN_W    = FREQ_W + 1;
  localparam int DVS_W        = DIV_DEN_W + Q_W - 1;
  localparam int CNT_W        = $clog2(Q_W);
  localparam int CFG_INDEX_W  = 2;

  // lowest note is C, three semitones above the A of its octave group
  localparam logic [SEMI_W-1:0] SEMI_START = SEMI_W'(3);
  localparam logic [SEMI_W-1:0] SEMI_LAST  = SEMI_W'(11);
  localparam logic [4:0]        SHIFT_BASE = 5'd19;

  localparam logic [FREQ_W-1:0] REF_A_RESET = FREQ_W'(112640);
  localparam logic [THR_W-1:0]  THR_RESET   = THR_W'(1966);

  localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_A = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_TOL   = CFG_INDEX_W'(1);

  // round(2^(s/12) * 2^16), UQ1.16
  localparam logic [RATIO_W-1:0] SEMITONE_RATIO [12] = '{
    17'd65536,  17'd69433,  17'd73562,  17'd77936,
    17'd82570,  17'd87480,  17'd92682,  17'd98193,
    17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  typedef struct packed {
    logic                   hit;
    logic [NOTE_W-1:0]      n;
    logic [NOTE_FULL_W-1:0] note;
    logic [NOTE_FULL_W-1:0] diff;
    logic                   above;
  } scan_res_t;

endpackage

`default_nettype wire

### src/mcls_scan.sv
// note sweep: shared multiplier plus a short pipeline forming and testing each note
`default_nettype none

module mcls_scan (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [mcls_pkg::FREQ_W-1:0]  freq,
  input  wire logic [mcls_pkg::FREQ_W-1:0]  ref_a,
  input  wire logic [mcls_pkg::THR_W-1:0]   thr,
  output logic                              res_valid,
  output mcls_pkg::scan_res_t               res
);

  logic                               busy;
  logic                               thr_phase;
  logic                               issuing;
  logic [mcls_pkg::NOTE_W-1:0]        n_issue;
  logic [mcls_pkg::SEMI_W-1:0]        semi;
  logic [mcls_pkg::OCT_W-1:0]         oct;
  logic [mcls_pkg::THRF_W-1:0]        thrf;

  logic                               v1;
  logic [mcls_pkg::NOTE_W-1:0]        n1;
  logic [mcls_pkg::OCT_W-1:0]         m1;
  logic [mcls_pkg::PROD_W-1:0]        prod1;
  logic                               v2;
  logic [mcls_pkg::NOTE_W-1:0]        n2;
  logic [mcls_pkg::NOTE_FULL_W-1:0]   note2;
  logic                               v3;
  logic [mcls_pkg::NOTE_W-1:0]        n3;
  logic [mcls_pkg::NOTE_FULL_W-1:0]   note3;
  logic [mcls_pkg::NOTE_FULL_W-1:0]   diff3;
  logic                               above3;

  logic [mcls_pkg::FREQ_W-1:0]        mul_a;
  logic [mcls_pkg::FREQ_W-1:0]        mul_b;
  logic [mcls_pkg::MUL_W-1:0]         mul_p;
  logic [mcls_pkg::ROUND_W-1:0]       round_sum;
  logic [mcls_pkg::NOTE_FULL_W-1:0]   note_calc;
  logic [mcls_pkg::NOTE_FULL_W-1:0]   freq_ext;
  logic                               above_calc;
  logic [mcls_pkg::NOTE_FULL_W-1:0]   diff_calc;
  logic                               hit_calc;
  logic                               last_issue;

  // the one multiplier: threshold times frequency once, then reference times ratio
  always_comb begin
    mul_a = thr_phase ? freq : ref_a;
    mul_b = thr_phase ? mcls_pkg::FREQ_W'(thr)
                      : mcls_pkg::FREQ_W'(mcls_pkg::SEMITONE_RATIO[semi]);
    mul_p = mul_a * mul_b;
  end

  // round half up while scaling by the octave
  always_comb begin
    round_sum = mcls_pkg::ROUND_W'(prod1)
              + (mcls_pkg::ROUND_W'(1) << (mcls_pkg::SHIFT_BASE - 5'd1 - 5'(m1)));
    note_calc = mcls_pkg::NOTE_FULL_W'(round_sum >> (mcls_pkg::SHIFT_BASE - 5'(m1)));
  end

  always_comb begin
    freq_ext   = mcls_pkg::NOTE_FULL_W'(freq);
    above_calc = freq_ext > note2;
    diff_calc  = above_calc ? (freq_ext - note2) : (note2 - freq_ext);
    hit_calc   = v3 && ({diff3, 16'b0} < mcls_pkg::CMP_W'(thrf));
    last_issue = n_issue == mcls_pkg::NOTE_W'(mcls_pkg::NOTE_COUNT - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      thr_phase <= 1'b0;
      issuing   <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      v1        <= issuing;
      v2        <= v1;
      v3        <= v2;
      n2        <= n1;
      note2     <= note_calc;
      n3        <= n2;
      note3     <= note2;
      diff3     <= diff_calc;
      above3    <= above_calc;
      if (start) begin
        busy      <= 1'b1;
        thr_phase <= 1'b1;
        issuing   <= 1'b0;
        n_issue   <= '0;
        semi      <= mcls_pkg::SEMI_START;
        oct       <= '0;
        v1        <= 1'b0;
        v2        <= 1'b0;
        v3        <= 1'b0;
      end else if (busy) begin
        if (thr_phase) begin
          thrf      <= mul_p[mcls_pkg::THRF_W-1:0];
          thr_phase <= 1'b0;
          issuing   <= 1'b1;
        end
        if (issuing) begin
          prod1   <= mul_p[mcls_pkg::PROD_W-1:0];
          n1      <= n_issue;
          m1      <= oct;
          n_issue <= n_issue + 1'b1;
          if (semi == mcls_pkg::SEMI_LAST) begin
            semi <= '0;
            oct  <= oct + 1'b1;
          end else begin
            semi <= semi + 1'b1;
          end
          if (last_issue) begin
            issuing <= 1'b0;
          end
        end
        if (hit_calc) begin
          // lowest matching note wins, drop the rest in flight
          res_valid <= 1'b1;
          res.hit   <= 1'b1;
          res.n     <= n3;
          res.note  <= note3;
          res.diff  <= diff3;
          res.above <= above3;
          busy      <= 1'b0;
          issuing   <= 1'b0;
          v1        <= 1'b0;
          v2        <= 1'b0;
          v3        <= 1'b0;
        end else if (!issuing && !thr_phase && !v1 && !v2 && !v3) begin
          res_valid <= 1'b1;
          res.hit   <= 1'b0;
          busy      <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### src/mcls_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module mcls_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [mcls_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [mcls_pkg::DIV_DEN_W-1:0]  den,
  output logic                                 busy,
  output logic                                 done,
  output logic [mcls_pkg::Q_W-1:0]             quot
);

  logic [mcls_pkg::DIV_NUM_W-1:0] rem;
  logic [mcls_pkg::DVS_W-1:0]     dvs;
  logic [mcls_pkg::CNT_W-1:0]     cnt;
  logic [mcls_pkg::DIV_NUM_W-1:0] dvs_ext;
  logic                           ge;

  always_comb begin
    dvs_ext = mcls_pkg::DIV_NUM_W'(dvs);
    ge      = rem >= dvs_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dvs  <= {den, (mcls_pkg::Q_W-1)'(0)};
        cnt  <= mcls_pkg::CNT_W'(mcls_pkg::Q_W - 1);
        quot <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dvs_ext;
        end
        quot <= {quot[mcls_pkg::Q_W-2:0], ge};
        dvs  <= dvs >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### src/musical_note_classifier.sv
// top level of the musical note classifier: config registers, sequencer, result register
//
// usage
//   s_* channel: one beat carries a measured frequency, UQ16.8 Hz, in s_tdata[23:0].
//   m_* channel: one beat per input; m_tuser is the found flag, m_tdata holds the
//   matched note index, its nominal frequency (saturated to 24 bits) and the
//   relative error 1 - note/f as Q1.15. all fields are zero when nothing matched.
//   cfg_* channel: index 0 writes reference_a, index 1 writes the match threshold,
//   other indexes are ignored. write only while no beat is in progress.
// timing
//   one shared multiplier forms threshold*f, then one note per cycle through a
//   three-stage note pipeline; the first note within threshold stops the sweep
//   and a 15-step bit-serial divider forms the error magnitude.
//   m_tvalid rises once the scan, for a match the divide, and the emit step are
//   through; s_tready is high only while the sequencer is idle, so a new input
//   is taken only once the previous one has been emitted.
// reset and stall
//   rst restores reference_a = 440 Hz and threshold = 1966, empties the result
//   register and returns the sequencer to idle. the result register holds a
//   finished beat while m_tready is low, so the next input can be accepted and
//   worked on; that next result then waits until the register frees up.
`default_nettype none

module musical_note_classifier (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [23:0]                         s_tdata,  // freq_hz[23:0]
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [47:0]                              m_tdata,  // note_index[6:0],
                                                             // note_freq[30:7],
                                                             // rel_error[46:31], pad
  output logic                                     m_tuser,  // found
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mcls_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [mcls_pkg::FREQ_W-1:0]         cfg_data
);

`include "musical_note_classifier_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t                              state;
  logic [mcls_pkg::FREQ_W-1:0]         ref_a;
  logic [mcls_pkg::THR_W-1:0]          thr;
  logic [mcls_pkg::FREQ_W-1:0]         freq;
  logic                                scan_start;

  // latched match
  logic                                hit;
  logic [mcls_pkg::NOTE_W-1:0]         hit_n;
  logic [mcls_pkg::NOTE_FULL_W-1:0]    hit_note;
  logic                                hit_above;

  logic                                res_valid;
  mcls_pkg::scan_res_t                 res;

  logic                                div_start;
  logic [mcls_pkg::DIV_NUM_W-1:0]      div_num;
  logic [mcls_pkg::DIV_DEN_W-1:0]      div_den;
  logic                                div_busy;
  logic                                div_done;
  logic [mcls_pkg::Q_W-1:0]            quot;
  logic [mcls_pkg::Q_W-1:0]            mag;

  logic [mcls_pkg::ERR_W-1:0]          err_calc;
  logic [mcls_pkg::FREQ_W-1:0]         note_sat;
  logic                                out_free;

  // result register payload
  logic                                out_found;
  logic [mcls_pkg::NOTE_W-1:0]         out_index;
  logic [mcls_pkg::FREQ_W-1:0]         out_freq;
  logic [mcls_pkg::ERR_W-1:0]          out_err;

  mcls_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .freq      (freq),
    .ref_a     (ref_a),
    .thr       (thr),
    .res_valid (res_valid),
    .res       (res)
  );

  // numerator diff*65536 + f stays below 2^40 for any match
  always_comb begin
    div_num = mcls_pkg::DIV_NUM_W'({res.diff, 16'b0} + mcls_pkg::CMP_W'(freq));
    div_den = {freq, 1'b0};
  end

  mcls_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    s_tready  = state == ST_IDLE;
    cfg_ready = 1'b1;
    // magnitude stays below 2^15 for any match, so no clamp is ever hit
    mag       = hit ? quot : '0;
    err_calc  = hit_above ? mcls_pkg::ERR_W'(mag)
                          : mcls_pkg::ERR_W'(0) - mcls_pkg::ERR_W'(mag);
    note_sat  = (|hit_note[mcls_pkg::NOTE_FULL_W-1:mcls_pkg::FREQ_W])
              ? {mcls_pkg::FREQ_W{1'b1}} : hit_note[mcls_pkg::FREQ_W-1:0];
    out_free  = !m_tvalid || m_tready;
    m_tdata   = {1'b0, out_err, out_freq, out_index};
    m_tuser   = out_found;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_a <= mcls_pkg::REF_A_RESET;
      thr   <= mcls_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mcls_pkg::REG_REFERENCE_A: ref_a <= cfg_data;
        mcls_pkg::REG_MATCH_TOL:   thr   <= cfg_data[mcls_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_start <= 1'b0;
      div_start  <= 1'b0;
      m_tvalid   <= 1'b0;
      hit        <= 1'b0;
    end else begin
      scan_start <= 1'b0;
      div_start  <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            freq       <= s_tdata;
            scan_start <= 1'b1;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (res_valid) begin
            hit       <= res.hit;
            hit_n     <= res.n;
            hit_note  <= res.note;
            hit_above <= res.above;
            if (res.hit) begin
              div_start <= 1'b1;
              state     <= ST_DIVIDE;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // hold the finished beat until the result register is free
          if (out_free) begin
            m_tvalid  <= 1'b1;
            out_found <= hit;
            out_index <= hit ? hit_n : '0;
            out_freq  <= hit ? note_sat : '0;
            out_err   <= hit ? err_calc : '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MCLS_ASSERT_IMPLY(a_nofind_zero, m_tvalid && !m_tuser,
    m_tdata == 48'd0, "result without a match carries nonzero fields")
  `MCLS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready,
    "input accepted again while an item is in progress")
  `MCLS_ASSERT_IMPLY(a_div_owner, div_done || div_busy, state == ST_DIVIDE,
    "divider active outside the divide step")

endmodule

`default_nettype wire

### dv/musical_note_classifier_tb.sv
// self-checking testbench of the musical note classifier: note prediction, handshakes, stalls
module musical_note_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT     = 4000;  // cycles with no beat on any channel
  localparam int ITEMS_PER_PHASE = 250;
  localparam int PHASE_COUNT     = 8;
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off in the first phase
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 150;   // about one worst-case beat of latency
  localparam int MAX_REPORTS     = 10;
  localparam int IDLE_PCT        = 82;
  localparam int BOTH_PCT        = 24;

  // indexes the block ignores
  localparam logic [mcls_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = mcls_pkg::CFG_INDEX_W'(2);
  localparam logic [mcls_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = mcls_pkg::CFG_INDEX_W'(3);

  // 2^(s/12) in UQ1.16, one entry per semitone above A
  localparam logic [16:0] SEMI_STEP [12] = '{
    17'd65536,  17'd69433,  17'd73562,  17'd77936,
    17'd82570,  17'd87480,  17'd92682,  17'd98193,
    17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  typedef struct packed {
    logic [23:0] probe;  // measured frequency that caused the result, for reports only
    logic        found;
    logic [6:0]  index;
    logic [23:0] freq;
    logic [15:0] err;
  } note_result_t;

  // keeps its own tuning and threshold, predicts each classification in arrival order
  class note_tracker;
    logic [23:0]  ref_a;
    logic [15:0]  thr;
    note_result_t awaited_notes[$];
    int           mismatches;

    function new();
      ref_a      = mcls_pkg::REF_A_RESET;
      thr        = mcls_pkg::THR_RESET;
      mismatches = 0;
    endfunction

    function void set_reg(logic [mcls_pkg::CFG_INDEX_W-1:0] idx, logic [23:0] data);
      case (idx)
        mcls_pkg::REG_REFERENCE_A: ref_a = data;
        mcls_pkg::REG_MATCH_TOL:   thr   = data[15:0];
        default: ;
      endcase
    endfunction

    // nominal note n in UQ16.8, full width before saturation
    function logic [63:0] nominal_freq(int unsigned n);
      int unsigned octv;
      int unsigned semi;
      int unsigned sh;
      logic [63:0] prod;
      octv = (n + 3) / 12;
      semi = (n + 3) % 12;
      sh   = 19 - octv;
      prod = 64'(ref_a) * 64'(SEMI_STEP[semi]);
      return (prod + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function note_result_t classify_pitch(logic [23:0] f);
      note_result_t res;
      logic [63:0]  nom;
      logic [63:0]  diff;
      logic [63:0]  mag;
      logic         above;
      res       = '0;
      res.probe = f;
      if (f == '0) return res;
      // first note from the bottom that lies strictly inside the threshold wins
      for (int n = 0; n < mcls_pkg::NOTE_COUNT; n++) begin
        nom   = nominal_freq(n);
        above = 64'(f) > nom;
        diff  = above ? 64'(f) - nom : nom - 64'(f);
        if ((diff << 16) < 64'(thr) * 64'(f)) begin
          mag       = ((diff << 16) + 64'(f)) / (64'(f) << 1);
          res.found = 1'b1;
          res.index = 7'(n);
          res.freq  = (nom > 64'hFFFFFF) ? 24'hFFFFFF : nom[23:0];
          if (above)
            res.err = (mag > 64'd32767) ? 16'h7FFF : mag[15:0];
          else
            res.err = (mag > 64'd32768) ? 16'h8000 : 16'(17'h10000 - mag[16:0]);
          return res;
        end
      end
      return res;
    endfunction

    function void note_input(logic [23:0] f);
      awaited_notes.push_back(classify_pitch(f));
    endfunction

    function int pending();
      return awaited_notes.size();
    endfunction

    function void report_miss(string what, note_result_t want, note_result_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%s: in %h exp found %0b idx %0d freq %h err %h / %s %0b idx %0d freq %h err %h",
                 what, want.probe, want.found, want.index, want.freq, want.err,
                 "got found", got.found, got.index, got.freq, got.err);
    endfunction

    function void check_beat(logic found, logic [47:0] tdata);
      note_result_t want;
      note_result_t got;
      got       = '0;
      got.found = found;
      got.index = tdata[6:0];
      got.freq  = tdata[30:7];
      got.err   = tdata[46:31];
      if (awaited_notes.size() == 0) begin
        report_miss("unexpected result", got, got);
        return;
      end
      want = awaited_notes[0];
      awaited_notes.delete(0);
      got.probe = want.probe;
      if (got.found !== want.found || got.index !== want.index ||
          got.freq !== want.freq || got.err !== want.err)
        report_miss("note mismatch", want, got);
    endfunction
  endclass

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             s_tvalid  = 1'b0;
  logic                             s_tready;
  logic [23:0]                      s_tdata   = '0;  // freq_hz[23:0]
  logic                             m_tvalid;
  logic                             m_tready  = 1'b0;
  logic [47:0]                      m_tdata;  // note_index[6:0], note_freq[30:7],
                                              // rel_error[46:31]
  logic                             m_tuser;  // found
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [mcls_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [23:0]                      cfg_data  = '0;

  note_tracker book;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_req      = 0;  // bumped by the stimulus to start a hold-off
  int          hold_seen     = 0;
  int          hold_left     = 0;

  musical_note_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, or a long hold-off counted down here so the block backs up
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // every result beat is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_beat(m_tuser, m_tdata);
  end

  // watchdog: ends the run when no channel has moved a beat for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // one frequency beat, after a random idle gap; s_tvalid stays high for the next call
  task automatic send_freq(input logic [23:0] f);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && gap < 200 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= f;
    do @(posedge clk); while (!s_tready);
    book.note_input(f);
  endtask

  // sender stops until every predicted result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mcls_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(idx, data);
  endtask

  // only while idle: tuning, threshold (junk in the upper bits), then a write to a spare index
  task automatic load_config(input logic [23:0] ref_val, input logic [15:0] thr_val);
    write_reg(mcls_pkg::REG_REFERENCE_A, ref_val);
    write_reg(mcls_pkg::REG_MATCH_TOL, {8'($urandom), thr_val});
    write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, 24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // mostly frequencies near a note, scaled to the threshold, plus zeros, tiny and wild values
  function automatic logic [23:0] pick_freq();
    int unsigned kind;
    int unsigned spread;
    logic [63:0] nom;
    logic [63:0] delta;
    logic [63:0] f;
    kind = $urandom_range(99);
    if (kind < 5) return '0;
    if (kind < 20) return 24'($urandom);
    if (kind < 28) return 24'($urandom_range(1, 1023));
    spread = 2 * int'(book.thr) + 16;
    if (spread > 65535) spread = 65535;
    nom   = book.nominal_freq($urandom_range(mcls_pkg::NOTE_COUNT - 1));
    delta = (nom * 64'($urandom_range(0, spread))) >> 16;
    if ($urandom_range(1)) f = nom + delta;
    else f = (delta > nom) ? 64'd0 : nom - delta;
    if (f > 64'hFFFFFF) f = 64'hFFFFFF - 64'($urandom_range(0, 255));
    if (f == 0) f = 64'd1;
    return f[23:0];
  endfunction

  initial begin : stimulus
    logic [23:0] probes[$];
    logic [63:0] nom;
    book = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed, reset tuning: zero, field extremes, exact notes at both ends, A itself,
    // just inside and just past the threshold, a quarter tone between two notes
    probes.push_back(24'd0);
    probes.push_back(24'd1);
    probes.push_back(24'hFFFFFF);
    probes.push_back(24'd112640);
    probes.push_back(24'(book.nominal_freq(0)));
    probes.push_back(24'(book.nominal_freq(mcls_pkg::NOTE_COUNT - 1)));
    nom = book.nominal_freq(33);
    probes.push_back(24'(nom + ((nom * 1900) >> 16)));
    probes.push_back(24'(nom + ((nom * 2100) >> 16)));
    nom = book.nominal_freq(12);
    probes.push_back(24'(nom - ((nom * 1965) >> 16)));
    probes.push_back(24'((book.nominal_freq(40) * 67497) >> 16));
    probes.push_back(24'h800000);
    probes.push_back(24'h7FFFFF);
    probes.push_back(24'h000100);
    probes.push_back(24'h555555);
    probes.push_back(24'hAAAAAA);
    foreach (probes[i]) send_freq(probes[i]);
    drain();

    // top tuning and widest threshold: notes above 24 bits saturate, large errors
    load_config(24'hFFFFFF, 16'hFFFF);
    send_freq(24'hFFFFFF);
    send_freq(24'h800000);
    send_freq(24'hC00000);
    send_freq(24'h100000);
    send_freq(24'd1);
    drain();

    // zero threshold: nothing matches
    load_config(mcls_pkg::REF_A_RESET, 16'd0);
    send_freq(24'd112640);
    send_freq(24'd56320);
    send_freq(24'h000001);
    drain();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;        stall_pct = 0;        end
        1: begin send_idle_pct = IDLE_PCT; stall_pct = 0;        end
        2: begin send_idle_pct = 0;        stall_pct = IDLE_PCT; end
        default: begin send_idle_pct = BOTH_PCT; stall_pct = BOTH_PCT; end
      endcase
      case (ph)
        0: load_config(mcls_pkg::REF_A_RESET, mcls_pkg::THR_RESET);
        1: load_config(24'($urandom_range(102400, 122880)), mcls_pkg::THR_RESET);
        2: load_config(24'd1, 16'hFFFF);
        3: load_config(24'hFFFFFF, 16'hFFFF);
        4: load_config(24'($urandom_range(1, 24'hFFFFFF)), 16'd0);
        5: load_config(24'($urandom_range(1, 24'hFFFFFF)), 16'($urandom));
        6: load_config(mcls_pkg::REF_A_RESET, 16'd1);
        default: load_config(24'($urandom_range(256, 24'h3FFFFF)),
                             16'($urandom_range(1, 4000)));
      endcase
      // receiver goes quiet while the sender keeps pushing: the block fills and stalls
      if (ph == 0) hold_req <= hold_req + 1;
      repeat (ITEMS_PER_PHASE) send_freq(pick_freq());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
